// File: design/light_flicker_detector_macros.svh
// Assertion helpers shared by the RTL. Each use expects clk and arst_n in scope.
`ifndef LIGHT_FLICKER_DETECTOR_MACROS_SVH
`define LIGHT_FLICKER_DETECTOR_MACROS_SVH

// Same-cycle implication.
`define LFD_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("light_flicker_detector: same-cycle check failed");

// Next-cycle implication.
`define LFD_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("light_flicker_detector: next-cycle check failed");

`endif

// File: design/lfd_pkg.sv
package lfd_pkg;

	localparam int LEVEL_W      = 10;
	localparam int THRESH_W     = 10;
	localparam int WLEN_W       = 9;
	localparam int EDGES_W      = 9;
	localparam int HITS_W       = 8;
	localparam int PERIOD_W     = 12;
	localparam int SPAN_W       = 16;
	localparam int FLICK_W      = 4;
	localparam int TIME_W       = 16;
	localparam int EDGE_TOTAL_W = 9;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	// register indexes on the config port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EDGE_THRESHOLD   = 3'd0,
		REG_WINDOW_LEN       = 3'd1,
		REG_MIN_EDGES        = 3'd2,
		REG_MAX_EDGES        = 3'd3,
		REG_HITS_NEEDED      = 3'd4,
		REG_SAMPLE_PERIOD_MS = 3'd5,
		REG_MAX_SPAN_MS      = 3'd6,
		REG_ALARM_FLICKERS   = 3'd7
	} cfg_reg_t;

	// reset values of the registers
	localparam logic [THRESH_W-1:0] RST_EDGE_THRESHOLD   = 10'd40;
	localparam logic [WLEN_W-1:0]   RST_WINDOW_LEN       = 9'd300;
	localparam logic [EDGES_W-1:0]  RST_MIN_EDGES        = 9'd40;
	localparam logic [EDGES_W-1:0]  RST_MAX_EDGES        = 9'd95;
	localparam logic [HITS_W-1:0]   RST_HITS_NEEDED      = 8'd10;
	localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD_MS = 12'd10;
	localparam logic [SPAN_W-1:0]   RST_MAX_SPAN_MS      = 16'd700;
	localparam logic [FLICK_W-1:0]  RST_ALARM_FLICKERS   = 4'd3;

	// what the front stage hands to the count stage
	typedef struct packed {
		logic edge_bit;   // step of this sample exceeded the threshold
		logic drop_old;   // window full: retire the oldest edge bit
		logic full;       // window holds weff+1 samples after this sample
	} s1_tok_t;

endpackage

// File: design/lfd_edge_ring.sv
module lfd_edge_ring #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_bit,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_bit
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_bit;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_bit <= mem[rd_addr];
		end
	end

endmodule

// File: design/light_flicker_detector.sv
// Light flicker detector. One light sample is taken per transaction on the
// input channel and one result per sample leaves on the output channel. The
// block sustains one sample per clock while the output is not stalled. A
// result is offered once the accepting edge has done the registered read of
// the edge ring memory and loaded the front stage, and a later edge at which
// the output register can take it has run the count stage into the output
// register. With the output stalled, one result and one sample are held
// before in_ready drops. The edge ring needs no clearing pass: a fill count
// guarantees only entries written since the last window restart are used.
// Configuration writes are taken at any time but must only be issued while
// the block is idle; writing window_len restarts the window.
`include "light_flicker_detector_macros.svh"

module light_flicker_detector #(
	parameter int WINDOW_DEPTH = 512,
	parameter int SPAN_EDGES   = 11
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lfd_pkg::LEVEL_W-1:0]         light_level,
	// result output
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                window_ready,
	output logic                                flicker,
	output logic                                alarm,
	output logic [lfd_pkg::EDGE_TOTAL_W-1:0]    edge_total,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lfd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import lfd_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);   // ring address
	localparam int FW = AW + 1;                 // fill count, holds up to WINDOW_DEPTH
	localparam int CW = AW;                     // edge count, at most WINDOW_DEPTH-1
	localparam int LW = (AW > WLEN_W) ? AW : WLEN_W;
	localparam int PW = TIME_W + PERIOD_W;      // span product

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [THRESH_W-1:0] thresh_q;
	logic [WLEN_W-1:0]   win_len_q;
	logic [EDGES_W-1:0]  min_edges_q;
	logic [EDGES_W-1:0]  max_edges_q;
	logic [HITS_W-1:0]   hits_needed_q;
	logic [PERIOD_W-1:0] period_q;
	logic [SPAN_W-1:0]   max_span_q;
	logic [FLICK_W-1:0]  alarm_flickers_q;

	logic cfg_wr;
	logic win_restart;

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign win_restart = cfg_wr && (cfg_reg_t'(cfg_index) == REG_WINDOW_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q         <= RST_EDGE_THRESHOLD;
			win_len_q        <= RST_WINDOW_LEN;
			min_edges_q      <= RST_MIN_EDGES;
			max_edges_q      <= RST_MAX_EDGES;
			hits_needed_q    <= RST_HITS_NEEDED;
			period_q         <= RST_SAMPLE_PERIOD_MS;
			max_span_q       <= RST_MAX_SPAN_MS;
			alarm_flickers_q <= RST_ALARM_FLICKERS;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(cfg_index))
				REG_EDGE_THRESHOLD:   thresh_q         <= cfg_data[THRESH_W-1:0];
				REG_WINDOW_LEN:       win_len_q        <= cfg_data[WLEN_W-1:0];
				REG_MIN_EDGES:        min_edges_q      <= cfg_data[EDGES_W-1:0];
				REG_MAX_EDGES:        max_edges_q      <= cfg_data[EDGES_W-1:0];
				REG_HITS_NEEDED:      hits_needed_q    <= cfg_data[HITS_W-1:0];
				REG_SAMPLE_PERIOD_MS: period_q         <= cfg_data[PERIOD_W-1:0];
				REG_MAX_SPAN_MS:      max_span_q       <= cfg_data[SPAN_W-1:0];
				REG_ALARM_FLICKERS:   alarm_flickers_q <= cfg_data[FLICK_W-1:0];
				default: ;
			endcase
		end
	end

	// effective window: zero acts as one, clamp to ring depth minus one
	logic [LW-1:0] wlen_ext;
	logic [AW-1:0] weff;

	always_comb begin
		wlen_ext = LW'(win_len_q);
		if (wlen_ext == '0) begin
			wlen_ext = LW'(1);
		end
		if (wlen_ext > LW'(WINDOW_DEPTH - 1)) begin
			wlen_ext = LW'(WINDOW_DEPTH - 1);
		end
		weff = AW'(wlen_ext);
	end

	// ---------------------------------------------------------------
	// Handshake: s1 token plus output register
	// ---------------------------------------------------------------
	logic    valid_s1;
	s1_tok_t tok_s1;
	logic    s1_move;
	logic    accept;
	logic    out_valid_q;

	assign s1_move   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || s1_move;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// ---------------------------------------------------------------
	// Front stage: edge detect, ring write and read, edge times
	// ---------------------------------------------------------------
	logic [LEVEL_W-1:0] last_q;
	logic [AW-1:0]      rp_q;
	logic [FW-1:0]      fill_q;
	logic [TIME_W-1:0]  sidx_q;
	logic [TIME_W-1:0]  times_q [SPAN_EDGES];
	logic [TIME_W-1:0]  dt_s1;

	logic               first;
	logic [LEVEL_W-1:0] step;
	logic               edge_now;
	logic [FW-1:0]      w_plus1;
	logic               at_full;
	logic [FW-1:0]      fill_nxt;
	logic [AW-1:0]      old_addr;
	logic [AW-1:0]      rp_nxt;
	logic [TIME_W-1:0]  newest;
	logic [TIME_W-1:0]  oldest;
	logic               old_bit;

	always_comb begin
		first    = (fill_q == '0);
		step     = (light_level > last_q) ? (light_level - last_q) : (last_q - light_level);
		edge_now = !first && (step > thresh_q);
		w_plus1  = FW'(weff) + FW'(1);
		at_full  = !first && (fill_q >= w_plus1);
		if (first) begin
			fill_nxt = FW'(1);
		end else if (at_full) begin
			fill_nxt = fill_q;
		end else begin
			fill_nxt = fill_q + FW'(1);
		end
		// oldest pair leaving the window sits weff entries behind the pointer
		if (rp_q >= weff) begin
			old_addr = rp_q - weff;
		end else begin
			old_addr = AW'({1'b0, rp_q} + (AW + 1)'(WINDOW_DEPTH) - {1'b0, weff});
		end
		rp_nxt = (rp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : rp_q + AW'(1);
		// time span over all times_q entries after this sample
		if (edge_now) begin
			newest = sidx_q;
			oldest = times_q[1];
		end else begin
			newest = times_q[SPAN_EDGES-1];
			oldest = times_q[0];
		end
	end

	lfd_edge_ring #(
		.DEPTH (WINDOW_DEPTH),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.wr_en   (accept && !first),
		.wr_addr (rp_q),
		.wr_bit  (edge_now),
		.rd_en   (accept),
		.rd_addr (old_addr),
		.rd_bit  (old_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			rp_q   <= '0;
			fill_q <= '0;
			sidx_q <= '0;
			for (int i = 0; i < SPAN_EDGES; i++) begin
				times_q[i] <= '0;
			end
		end else if (win_restart) begin
			rp_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			last_q <= light_level;
			sidx_q <= sidx_q + TIME_W'(1);
			fill_q <= fill_nxt;
			if (!first) begin
				rp_q <= rp_nxt;
			end
			if (edge_now) begin
				for (int i = 0; i < SPAN_EDGES - 1; i++) begin
					times_q[i] <= times_q[i+1];
				end
				times_q[SPAN_EDGES-1] <= sidx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the token, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1.edge_bit <= edge_now;
			tok_s1.drop_old <= at_full;
			tok_s1.full     <= (fill_nxt >= w_plus1);
			dt_s1           <= newest - oldest;
		end
	end

	// ---------------------------------------------------------------
	// Count stage: edge count, hits, span check, flicker count
	// ---------------------------------------------------------------
	logic [CW-1:0]      edge_count_q;
	logic [HITS_W-1:0]  hit_q;
	logic [FLICK_W-1:0] fcnt_q;

	logic [CW-1:0]      ec_nxt;
	logic [HITS_W-1:0]  hit_inc;
	logic [HITS_W-1:0]  hit_nxt;
	logic [FLICK_W-1:0] fcnt_inc;
	logic [FLICK_W-1:0] fcnt_nxt;
	logic [PW-1:0]      span;
	logic               flick_now;
	logic               alarm_now;

	always_comb begin
		ec_nxt    = edge_count_q - CW'(tok_s1.drop_old && old_bit) + CW'(tok_s1.edge_bit);
		span      = PW'(dt_s1) * PW'(period_q);
		hit_inc   = hit_q;
		hit_nxt   = hit_q;
		fcnt_inc  = fcnt_q + FLICK_W'(1);
		fcnt_nxt  = fcnt_q;
		flick_now = 1'b0;
		alarm_now = 1'b0;
		if (tok_s1.full) begin
			if ((LW'(ec_nxt) >= LW'(min_edges_q)) && (LW'(ec_nxt) <= LW'(max_edges_q))) begin
				hit_inc = hit_q + HITS_W'(1);
			end
			hit_nxt = hit_inc;
			if (hit_inc >= hits_needed_q) begin
				hit_nxt   = '0;
				flick_now = (LW'(ec_nxt) >= LW'(SPAN_EDGES)) && (span <= PW'(max_span_q));
			end
			if (flick_now) begin
				fcnt_nxt = fcnt_inc;
				if (fcnt_inc >= alarm_flickers_q) begin
					alarm_now = 1'b1;
					fcnt_nxt  = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			hit_q        <= '0;
			fcnt_q       <= '0;
		end else if (win_restart) begin
			edge_count_q <= '0;
		end else if (s1_move) begin
			edge_count_q <= ec_nxt;
			hit_q        <= hit_nxt;
			fcnt_q       <= fcnt_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			window_ready <= tok_s1.full;
			flicker      <= flick_now;
			alarm        <= alarm_now;
			edge_total   <= EDGE_TOTAL_W'({{EDGE_TOTAL_W{1'b0}}, ec_nxt});
		end
	end

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`LFD_ASSERT_NOW(a_alarm_needs_flicker, out_valid_q && alarm, flicker)
	`LFD_ASSERT_NOW(a_flicker_needs_full, out_valid_q && flicker, window_ready)
	`LFD_ASSERT_NOW(a_edges_within_window, 1'b1, edge_count_q <= weff)
	`LFD_ASSERT_NOW(a_no_token_overrun, accept && valid_s1, s1_move)
	`LFD_ASSERT_NEXT(a_token_lands, s1_move, out_valid_q)

endmodule

// File: bench/flicker_checker.sv
module flicker_checker #(
	parameter int WINDOW_DEPTH = 512,
	parameter int SPAN_EDGES   = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [lfd_pkg::LEVEL_W-1:0]      light_level,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic                             window_ready,
	input  logic                             flicker,
	input  logic                             alarm,
	input  logic [lfd_pkg::EDGE_TOTAL_W-1:0] edge_total,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [lfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                               fails,
	output int                               backlog
);
	timeunit 1ns;
	timeprecision 1ps;
	import lfd_pkg::*;

	typedef struct packed {
		logic                    window_ready;
		logic                    flicker;
		logic                    alarm;
		logic [EDGE_TOTAL_W-1:0] edge_total;
	} sample_verdict_t;

	sample_verdict_t verdicts_due[$];

	// register copies
	logic [THRESH_W-1:0] step_limit;
	logic [WLEN_W-1:0]   win_len;
	logic [EDGES_W-1:0]  edges_lo;
	logic [EDGES_W-1:0]  edges_hi;
	logic [HITS_W-1:0]   hits_goal;
	logic [PERIOD_W-1:0] period_ms;
	logic [SPAN_W-1:0]   span_limit;
	logic [FLICK_W-1:0]  flicks_per_alarm;

	// window and detector state
	bit                  edge_bits [WINDOW_DEPTH];
	logic [LEVEL_W-1:0]  prev_level;
	int unsigned         ring_pos;
	int unsigned         filled;
	int unsigned         edges_in_window;
	logic [TIME_W-1:0]   edge_stamp [SPAN_EDGES];
	logic [TIME_W-1:0]   sample_no;
	logic [HITS_W-1:0]   hit_cnt;
	logic [FLICK_W-1:0]  flick_cnt;

	function automatic void restart_window();
		foreach (edge_bits[i])
			edge_bits[i] = 1'b0;
		ring_pos        = 0;
		filled          = 0;
		edges_in_window = 0;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	// advance the window by one sample and work out what the block reports for it
	function automatic sample_verdict_t judge_sample(input logic [LEVEL_W-1:0] lvl);
		sample_verdict_t   v;
		int unsigned       w;
		int unsigned       step;
		int unsigned       oldest;
		bit                is_edge;
		logic [TIME_W-1:0] dt;
		longint unsigned   span;
		v = '0;
		w = (win_len == 0) ? 1 : win_len;
		if (w > WINDOW_DEPTH - 1)
			w = WINDOW_DEPTH - 1;
		if (filled == 0) begin
			filled = 1;
		end else begin
			step    = (lvl > prev_level) ? lvl - prev_level : prev_level - lvl;
			is_edge = step > step_limit;
			if (filled >= w + 1) begin
				oldest = (ring_pos + WINDOW_DEPTH - w) % WINDOW_DEPTH;
				edges_in_window -= edge_bits[oldest];
			end else begin
				filled++;
			end
			edge_bits[ring_pos] = is_edge;
			edges_in_window += is_edge;
			ring_pos = (ring_pos + 1) % WINDOW_DEPTH;
			if (is_edge) begin
				for (int i = 0; i < SPAN_EDGES - 1; i++)
					edge_stamp[i] = edge_stamp[i+1];
				edge_stamp[SPAN_EDGES-1] = sample_no;
			end
		end
		prev_level = lvl;
		sample_no  = sample_no + 1'b1;

		v.window_ready = filled >= w + 1;
		if (v.window_ready) begin
			if (edges_in_window >= edges_lo && edges_in_window <= edges_hi)
				hit_cnt = hit_cnt + 1'b1;
			if (hit_cnt >= hits_goal) begin
				if (edges_in_window >= SPAN_EDGES) begin
					dt   = edge_stamp[SPAN_EDGES-1] - edge_stamp[0];
					span = 64'(dt) * 64'(period_ms);
					if (span <= span_limit)
						v.flicker = 1'b1;
				end
				hit_cnt = '0;
			end
			if (v.flicker) begin
				flick_cnt = flick_cnt + 1'b1;
				if (flick_cnt >= flicks_per_alarm) begin
					v.alarm   = 1'b1;
					flick_cnt = '0;
				end
			end
		end
		v.edge_total = edges_in_window[EDGE_TOTAL_W-1:0];
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_verdict_t due;
		if (!arst_n) begin
			step_limit       = RST_EDGE_THRESHOLD;
			win_len          = RST_WINDOW_LEN;
			edges_lo         = RST_MIN_EDGES;
			edges_hi         = RST_MAX_EDGES;
			hits_goal        = RST_HITS_NEEDED;
			period_ms        = RST_SAMPLE_PERIOD_MS;
			span_limit       = RST_MAX_SPAN_MS;
			flicks_per_alarm = RST_ALARM_FLICKERS;
			restart_window();
			prev_level = '0;
			foreach (edge_stamp[i])
				edge_stamp[i] = '0;
			sample_no = '0;
			hit_cnt   = '0;
			flick_cnt = '0;
			verdicts_due.delete();
			fails   = 0;
			backlog = 0;
		end else begin
			// results first: a sample taken at this edge cannot be the one leaving
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					$error("result transaction with no sample outstanding");
					fails++;
				end else begin
					due = verdicts_due.pop_front();
					check_field("window_ready", due.window_ready, window_ready);
					check_field("flicker", due.flicker, flicker);
					check_field("alarm", due.alarm, alarm);
					check_field("edge_total", due.edge_total, edge_total);
				end
			end
			if (in_valid && in_ready)
				verdicts_due = {verdicts_due, judge_sample(light_level)};
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_EDGE_THRESHOLD:   step_limit = cfg_data[THRESH_W-1:0];
					REG_WINDOW_LEN: begin
						win_len = cfg_data[WLEN_W-1:0];
						restart_window();
					end
					REG_MIN_EDGES:        edges_lo = cfg_data[EDGES_W-1:0];
					REG_MAX_EDGES:        edges_hi = cfg_data[EDGES_W-1:0];
					REG_HITS_NEEDED:      hits_goal = cfg_data[HITS_W-1:0];
					REG_SAMPLE_PERIOD_MS: period_ms = cfg_data[PERIOD_W-1:0];
					REG_MAX_SPAN_MS:      span_limit = cfg_data[SPAN_W-1:0];
					REG_ALARM_FLICKERS:   flicks_per_alarm = cfg_data[FLICK_W-1:0];
					default: ;
				endcase
			end
			backlog = verdicts_due.size();
		end
	end

endmodule

// File: bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lfd_pkg::*;

	localparam int WINDOW_DEPTH = 512;
	localparam int SPAN_EDGES   = 11;
	localparam int PHASES       = 9;
	// watchdog limit; leave lots of headroom above the slowest run
	localparam int unsigned CYCLE_LIMIT = 300000;

	// opening samples at the power-on settings (threshold 40, window not yet full):
	// rail to rail swings, a step of exactly the threshold, one just above it,
	// alternating bit patterns and a repeated level
	localparam logic [LEVEL_W-1:0] OPENING_LEVELS [16] = '{
		10'd0, 10'd1023, 10'd0, 10'd40, 10'd81, 10'd81, 10'd1023, 10'd1022,
		10'd512, 10'd511, 10'd341, 10'd682, 10'd0, 10'd1023, 10'd983, 10'd1023
	};

	logic clk = 1'b0;
	logic arst_n;

	logic                    in_valid;
	logic                    in_ready;
	logic [LEVEL_W-1:0]      light_level;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    window_ready;
	logic                    flicker;
	logic                    alarm;
	logic [EDGE_TOTAL_W-1:0] edge_total;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	int fails;
	int backlog;

	// stall rates in percent, changed per group of phases
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	// what the stimulus needs to know of the current settings
	int unsigned        cur_thr;
	logic [WLEN_W-1:0]  win_raw;
	int unsigned        edge_pct;
	logic [LEVEL_W-1:0] last_level;

	int unsigned cycle_count = 0;

	always #5ns clk = ~clk;

	light_flicker_detector #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SPAN_EDGES  (SPAN_EDGES)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.light_level (light_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.window_ready(window_ready),
		.flicker     (flicker),
		.alarm       (alarm),
		.edge_total  (edge_total),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	flicker_checker #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SPAN_EDGES  (SPAN_EDGES)
	) watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.light_level (light_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.window_ready(window_ready),
		.flicker     (flicker),
		.alarm       (alarm),
		.edge_total  (edge_total),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fails       (fails),
		.backlog     (backlog)
	);

	// result side: ready toggles at random on the falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Next light level. Mostly a flicker-like stream: each step is either an
	// edge (step above the threshold) with probability edge_pct or a quiet step
	// at or below it, so the window edge count drifts around a chosen density.
	// A few samples are plain noise over the full range.
	function automatic logic [LEVEL_W-1:0] next_level(input logic [LEVEL_W-1:0] prev,
		input int unsigned thr, input int unsigned pct);
		int unsigned p;
		int unsigned mag;
		p = prev;
		if ($urandom_range(0, 99) < 6)
			return LEVEL_W'($urandom);
		if ($urandom_range(0, 99) < pct && thr < 1023)
			mag = $urandom_range(thr + 1, 1023);
		else
			mag = $urandom_range(0, thr);
		if (p + mag <= 1023 && (p < mag || $urandom_range(0, 1) == 1))
			return LEVEL_W'(p + mag);
		if (p >= mag)
			return LEVEL_W'(p - mag);
		// step too big either way: take the biggest one on offer
		return (p > 1023 - p) ? LEVEL_W'(0) : LEVEL_W'(1023);
	endfunction

	// register value, now and then with junk above the register's width
	function automatic logic [CFG_DATA_W-1:0] with_junk(input int unsigned value,
		input int width);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'(value);
		if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
			d = d | (CFG_DATA_W'($urandom) << width);
		return d;
	endfunction

	// one sample transaction; called and returns at a falling edge
	task automatic send_level(input logic [LEVEL_W-1:0] lvl);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		light_level <= lvl;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		last_level = lvl;
	endtask

	// stop sending until every sample has produced its result
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (backlog != 0);
	endtask

	// one config transaction; cfg_valid is left high for back-to-back writes
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Settings of one phase. Most phases get random settings sized so that
	// hits, span checks and alarms actually happen; a few pin the extremes.
	// Phases 2 and 8 keep the running window (no window_len write) so the
	// other registers change under a filled window.
	task automatic program_phase(input int ph);
		int unsigned w;
		int unsigned typical_edges;
		int unsigned lo;
		int unsigned hi;
		int unsigned hits;
		int unsigned period;
		int unsigned span;
		int unsigned nflick;
		bit          new_window;
		new_window = !(ph == 2 || ph == 8);
		if (new_window) begin
			w = $urandom_range(12, 40);
			if (ph == 5)
				w = $urandom_range(2, 10);   // too short to ever hold enough large steps for the span check
		end else begin
			w = win_raw;
		end
		edge_pct      = $urandom_range(25, 85);
		cur_thr       = $urandom_range(0, 300);
		typical_edges = (w * edge_pct) / 100;
		lo            = $urandom_range(0, typical_edges);
		hi            = $urandom_range(typical_edges, w);
		hits          = $urandom_range(0, 5);
		period        = $urandom_range(1, 60);
		span          = period * $urandom_range(8, 30);
		nflick        = $urandom_range(1, 4);
		case (ph)
			0: begin
				// window_len zero acts as one; no edges can pass a 1023 threshold
				w       = 0;
				cur_thr = 1023;
				lo      = 511;
				hi      = 0;
				hits    = 255;
				period  = 4095;
				span    = 65535;
				nflick  = 15;
			end
			1: begin
				// span check on every full-window sample, zero period, alarm each time
				cur_thr = 0;
				lo      = 0;
				hi      = 511;
				hits    = 0;
				period  = 0;
				span    = 0;
				nflick  = 0;
			end
			4: w = 511;          // longest window
			7: begin
				period = 4095;   // only tight spans of at most 16 samples pass
				span   = 65535;
			end
			default: ;
		endcase
		write_reg(REG_EDGE_THRESHOLD, with_junk(cur_thr, THRESH_W));
		if (new_window)
			write_reg(REG_WINDOW_LEN, with_junk(w, WLEN_W));
		write_reg(REG_MIN_EDGES, with_junk(lo, EDGES_W));
		write_reg(REG_MAX_EDGES, with_junk(hi, EDGES_W));
		write_reg(REG_HITS_NEEDED, with_junk(hits, HITS_W));
		write_reg(REG_SAMPLE_PERIOD_MS, with_junk(period, PERIOD_W));
		write_reg(REG_MAX_SPAN_MS, with_junk(span, SPAN_W));
		write_reg(REG_ALARM_FLICKERS, with_junk(nflick, FLICK_W));
		cfg_valid <= 1'b0;
		win_raw = WLEN_W'(w);
	endtask

	initial begin
		int unsigned weff;
		int unsigned n;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		light_level = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_EDGE_THRESHOLD;
		cfg_data    = '0;

		send_idle_pct = 28;
		recv_idle_pct = 67;
		cur_thr       = RST_EDGE_THRESHOLD;
		win_raw       = RST_WINDOW_LEN;
		edge_pct      = 50;
		last_level    = '0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening at the power-on settings
		foreach (OPENING_LEVELS[i])
			send_level(OPENING_LEVELS[i]);

		// random phases: receiver-heavy stalls, then sender-heavy, then none
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 67;
				recv_idle_pct = 28;
			end
			if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// settings change only with nothing in flight
			drain();
			program_phase(ph);
			weff = (win_raw == 0) ? 1 : win_raw;
			// enough samples to fill the window and then run past it
			n = weff + 1 + ((ph == 4) ? $urandom_range(20, 40) : $urandom_range(30, 60));
			repeat (n) begin
				// move the edge density now and then so the count wanders
				// into and out of the hit range
				if ($urandom_range(0, 39) == 0)
					edge_pct = $urandom_range(0, 100);
				if ($urandom_range(0, 149) == 0)
					drain();
				send_level(next_level(last_level, cur_thr, edge_pct));
			end
		end

		drain();
		repeat (5) @(negedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/lfd_pkg.sv
design/lfd_edge_ring.sv
design/light_flicker_detector.sv
bench/flicker_checker.sv
bench/tb_top.sv
